>>> sv/regex_pattern_tokenizer_defines.svh
// Assertion macros used by the tokenizer checker
`ifndef REGEX_PATTERN_TOKENIZER_DEFINES_SVH
`define REGEX_PATTERN_TOKENIZER_DEFINES_SVH

// check outside reset
`define RPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check at every edge, reset included
`define RPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/rpt_pkg.sv
// Token kinds, character codes and the plain-byte classifier of the tokenizer
package rpt_pkg;

  typedef enum logic [4:0] {
    TK_LITERAL  = 5'd0,
    TK_SPACE    = 5'd1,
    TK_WILDCARD = 5'd2,
    TK_LPAREN   = 5'd3,
    TK_RPAREN   = 5'd4,
    TK_LBRACKET = 5'd5,
    TK_DASH     = 5'd6,
    TK_RBRACKET = 5'd7,
    TK_LCURLY   = 5'd8,
    TK_RCURLY   = 5'd9,
    TK_COMMA    = 5'd10,
    TK_START    = 5'd11,
    TK_CARET    = 5'd12,
    TK_END      = 5'd13,
    TK_QUESTION = 5'd14,
    TK_STAR     = 5'd15,
    TK_PLUS     = 5'd16,
    TK_BAR      = 5'd17,
    TK_ERROR    = 5'd18
  } tk_kind_t;

  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_LCURLY   = 8'h7B;
  localparam logic [7:0] CH_RCURLY   = 8'h7D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_CARET    = 8'h5E;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_LOWER_T  = 8'h74;
  localparam logic [7:0] CH_LOWER_S  = 8'h73;
  localparam logic [7:0] CH_BAR      = 8'h7C;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_DASH     = 8'h2D;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_TAB      = 8'h09;

  function automatic tk_kind_t plain_kind(input logic [7:0] c, input logic at_start);
    tk_kind_t k;
    case (c)
      CH_DOT:      k = TK_WILDCARD;
      CH_LPAREN:   k = TK_LPAREN;
      CH_RPAREN:   k = TK_RPAREN;
      CH_LBRACKET: k = TK_LBRACKET;
      CH_DASH:     k = TK_DASH;
      CH_RBRACKET: k = TK_RBRACKET;
      CH_CARET:    k = at_start ? TK_START : TK_CARET;
      CH_DOLLAR:   k = TK_END;
      CH_QUESTION: k = TK_QUESTION;
      CH_STAR:     k = TK_STAR;
      CH_PLUS:     k = TK_PLUS;
      CH_BAR:      k = TK_BAR;
      CH_RCURLY:   k = TK_RCURLY;
      default:     k = TK_LITERAL;
    endcase
    return k;
  endfunction

endpackage

>>> sv/regex_pattern_tokenizer.sv
// Top level of the regex pattern tokenizer: input register, classifier, result register
//
// channel | dir | tdata                 | tuser
// s_      | in  | [7:0] pattern_char    | [0] first_of_pattern
// m_      | out | [7:0] token_char      | [4:0] token_kind
//
// One beat per cycle sustained while m_ is not stalled; a byte taken on s_ passes the input
// register and then the result register before its token reaches m_.
// rst clears both valid flags and the escape, brace and error flags.
// A stalled m_ side holds the result; s_tready drops once the input register is full too.
module regex_pattern_tokenizer
  import rpt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] pattern_char
  input  logic       s_tuser,   // [0] first_of_pattern
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] token_char
  output logic [4:0] m_tuser    // [4:0] token_kind
);

  logic       in_valid;
  logic [7:0] in_char;
  logic       in_first;

  logic escape_pending, escape_pending_next;
  logic inside_braces, inside_braces_next;
  logic error_latched, error_latched_next;

  logic       advance;
  logic       emit;
  tk_kind_t   kind;
  logic [7:0] tchar;
  logic       esc, brace, err;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_comb begin
    esc   = escape_pending && !in_first;
    brace = inside_braces && !in_first;
    err   = error_latched && !in_first;
    escape_pending_next = esc;
    inside_braces_next  = brace;
    error_latched_next  = err;
    emit  = 1'b1;
    kind  = TK_LITERAL;
    tchar = in_char;
    if (err) begin
      emit = 1'b0;
    end else if (brace) begin
      if (in_char == CH_COMMA) begin
        kind = TK_COMMA;
      end else if (in_char >= CH_ZERO && in_char <= CH_NINE) begin
        kind = TK_LITERAL;
      end else if (in_char == CH_RCURLY) begin
        kind = TK_RCURLY;
        inside_braces_next = 1'b0;
      end else begin
        kind = TK_ERROR;
        error_latched_next = 1'b1;
      end
    end else if (esc) begin
      escape_pending_next = 1'b0;
      if (in_char == CH_LOWER_T) begin
        tchar = CH_TAB;
      end else if (in_char == CH_LOWER_S) begin
        kind = TK_SPACE;
      end
    end else if (in_char == CH_BSLASH) begin
      escape_pending_next = 1'b1;
      emit = 1'b0;
    end else if (in_char == CH_LCURLY) begin
      inside_braces_next = 1'b1;
      kind = TK_LCURLY;
    end else begin
      kind = plain_kind(in_char, in_first);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata;
      in_first <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      inside_braces  <= 1'b0;
      error_latched  <= 1'b0;
      m_tvalid       <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid && emit;
      if (in_valid) begin
        escape_pending <= escape_pending_next;
        inside_braces  <= inside_braces_next;
        error_latched  <= error_latched_next;
      end
    end
    if (advance) begin
      m_tdata <= tchar;
      m_tuser <= kind;
    end
  end

endmodule

>>> sv/rpt_checker.sv
// Port-level checks of the tokenizer and their binding to the top level
`include "regex_pattern_tokenizer_defines.svh"

module rpt_checker
  import rpt_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [4:0] m_tuser
);

  logic anchor;

  assign anchor = (m_tuser == TK_START) || (m_tuser == TK_CARET);

  `RPT_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable({m_tuser, m_tdata}), "beat changed")
  `RPT_ASSERT_ALWAYS(a_rst_empty, rst |=> !m_tvalid, "result valid after reset")
  `RPT_ASSERT_ALWAYS(a_rst_ready, rst |=> s_tready, "input not ready after reset")
  `RPT_ASSERT(a_kind_range, m_tvalid |-> m_tuser <= TK_ERROR, "token kind out of range")
  `RPT_ASSERT(a_caret_char, m_tvalid && anchor |-> m_tdata == CH_CARET, "anchor without caret")

endmodule

bind regex_pattern_tokenizer rpt_checker u_rpt_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for regex_pattern_tokenizer: directed table, random patterns, token checks
`timescale 1ns / 100ps

module tb_top
  import rpt_pkg::*;
();

  localparam int STALL_LIMIT = 300;
  localparam int RAND_BYTES  = 700;
  localparam int SHOW_FAILS  = 10;

  typedef struct {
    logic [7:0] ch;
    logic       first;
    bit         fixed;
    bit         fx_tok;
    tk_kind_t   fx_kind;
    logic [7:0] fx_char;
  } stim_t;

  typedef struct {
    tk_kind_t   kind;
    logic [7:0] chr;
  } token_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] pattern_char
  logic       s_tuser = 1'b0;    // [0] first_of_pattern
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] token_char
  logic [4:0] m_tuser;           // [4:0] token_kind

  regex_pattern_tokenizer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stim_t  byte_q [$];
  token_t pending_tokens [$];
  stim_t  cur_item;
  bit     tx_busy = 1'b0;
  bit     idle_on = 1'b1;
  bit     pat_head = 1'b0;
  int     tx_gap = 0;
  int     rx_gap = 0;
  int     stall_cnt = 0;
  int     fail_cnt = 0;
  int     n_bytes = 0;
  int     n_live = 0;
  int     n_tokens = 0;
  int     n_err_tokens = 0;
  int     n_patterns = 0;

  bit esc_pend = 1'b0;
  bit in_brace = 1'b0;
  bit err_latched = 1'b0;

  logic [7:0] op_set [13] = '{CH_DOT, CH_LPAREN, CH_RPAREN, CH_LBRACKET, CH_DASH,
                              CH_RBRACKET, CH_CARET, CH_DOLLAR, CH_QUESTION, CH_STAR,
                              CH_PLUS, CH_BAR, CH_RCURLY};

  stim_t dir_tab [0:31] = '{
    '{CH_CARET,    1'b1, 1'b1, 1'b1, TK_START,   CH_CARET},
    '{CH_CARET,    1'b0, 1'b1, 1'b1, TK_CARET,   CH_CARET},
    '{8'h00,       1'b0, 1'b1, 1'b1, TK_LITERAL, 8'h00},
    '{8'hFF,       1'b0, 1'b1, 1'b1, TK_LITERAL, 8'hFF},
    '{CH_DOT,      1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LPAREN,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_RPAREN,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LBRACKET, 1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_DASH,     1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_RBRACKET, 1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_DOLLAR,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_QUESTION, 1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_STAR,     1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_PLUS,     1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_BAR,      1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_RCURLY,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_BSLASH,   1'b0, 1'b1, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LOWER_T,  1'b0, 1'b1, 1'b1, TK_LITERAL, CH_TAB},
    '{CH_BSLASH,   1'b0, 1'b1, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LOWER_S,  1'b0, 1'b1, 1'b1, TK_SPACE,   CH_LOWER_S},
    '{CH_BSLASH,   1'b0, 1'b1, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LCURLY,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LCURLY,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_ZERO,     1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_COMMA,    1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_RCURLY,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LCURLY,   1'b0, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_BSLASH,   1'b0, 1'b1, 1'b1, TK_ERROR,   CH_BSLASH},
    '{8'h78,       1'b0, 1'b1, 1'b0, TK_LITERAL, 8'h00},
    '{CH_BSLASH,   1'b1, 1'b1, 1'b0, TK_LITERAL, 8'h00},
    '{CH_LCURLY,   1'b1, 1'b0, 1'b0, TK_LITERAL, 8'h00},
    '{CH_CARET,    1'b1, 1'b1, 1'b1, TK_START,   CH_CARET}
  };

  function automatic void tokenize_byte(input logic [7:0] c, input logic first,
                                        output bit tok, output tk_kind_t kind,
                                        output logic [7:0] chr);
    tok  = 1'b1;
    kind = TK_LITERAL;
    chr  = c;
    if (first) begin
      esc_pend    = 1'b0;
      in_brace    = 1'b0;
      err_latched = 1'b0;
    end
    if (err_latched) begin
      tok = 1'b0;
    end else if (in_brace) begin
      if (c == CH_COMMA) begin
        kind = TK_COMMA;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        kind = TK_LITERAL;
      end else if (c == CH_RCURLY) begin
        kind     = TK_RCURLY;
        in_brace = 1'b0;
      end else begin
        kind        = TK_ERROR;
        err_latched = 1'b1;
      end
    end else if (esc_pend) begin
      esc_pend = 1'b0;
      if (c == CH_LOWER_T) begin
        chr = CH_TAB;
      end else if (c == CH_LOWER_S) begin
        kind = TK_SPACE;
      end
    end else begin
      case (c)
        CH_BSLASH: begin
          esc_pend = 1'b1;
          tok      = 1'b0;
        end
        CH_LCURLY: begin
          in_brace = 1'b1;
          kind     = TK_LCURLY;
        end
        CH_DOT:      kind = TK_WILDCARD;
        CH_LPAREN:   kind = TK_LPAREN;
        CH_RPAREN:   kind = TK_RPAREN;
        CH_LBRACKET: kind = TK_LBRACKET;
        CH_DASH:     kind = TK_DASH;
        CH_RBRACKET: kind = TK_RBRACKET;
        CH_CARET:    kind = first ? TK_START : TK_CARET;
        CH_DOLLAR:   kind = TK_END;
        CH_QUESTION: kind = TK_QUESTION;
        CH_STAR:     kind = TK_STAR;
        CH_PLUS:     kind = TK_PLUS;
        CH_BAR:      kind = TK_BAR;
        CH_RCURLY:   kind = TK_RCURLY;
        default:     kind = TK_LITERAL;
      endcase
    end
  endfunction

  task automatic take_byte(input stim_t it);
    bit         tok;
    tk_kind_t   kind;
    logic [7:0] chr;
    token_t     tk;
    if (it.first || !err_latched) n_live++;
    n_bytes++;
    tokenize_byte(it.ch, it.first, tok, kind, chr);
    if (it.fixed) begin
      tok  = it.fx_tok;
      kind = it.fx_kind;
      chr  = it.fx_char;
    end
    if (tok) begin
      tk = '{kind, chr};
      pending_tokens.insert(pending_tokens.size(), tk);
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    stim_t it;
    it = '{c, pat_head, 1'b0, 1'b0, TK_LITERAL, 8'h00};
    byte_q.insert(byte_q.size(), it);
    pat_head = 1'b0;
  endtask

  task automatic add_pattern();
    int         n_el;
    int         pick;
    int         nd;
    logic [7:0] rb;
    n_patterns++;
    pat_head = 1'b1;
    if ($urandom_range(0, 99) < 12) begin
      n_el = $urandom_range(1, 10);
      repeat (n_el) begin
        pat_head = ($urandom_range(0, 3) == 0);
        push_char(8'($urandom_range(0, 255)));
      end
      return;
    end
    n_el = $urandom_range(1, 8);
    repeat (n_el) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        push_char(op_set[4'($urandom_range(0, 12))]);
      end else if (pick < 45) begin
        push_char(CH_BSLASH);
        case ($urandom_range(0, 3))
          0:       push_char(CH_LOWER_T);
          1:       push_char(CH_LOWER_S);
          2:       push_char(CH_LCURLY);
          default: push_char(8'($urandom_range(0, 255)));
        endcase
      end else if (pick < 65) begin
        push_char(CH_LCURLY);
        nd = $urandom_range(1, 3);
        repeat (nd) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 1)) begin
          push_char(CH_COMMA);
          nd = $urandom_range(0, 2);
          repeat (nd) push_char(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 4) == 0) begin
          rb = 8'($urandom_range(0, 255));
          push_char(rb);
        end
        if ($urandom_range(0, 9) != 0) push_char(CH_RCURLY);
      end else if (pick < 85) begin
        push_char(8'h61 + 8'($urandom_range(0, 25)));
      end else begin
        push_char(8'($urandom_range(0, 255)));
      end
    end
    if ($urandom_range(0, 9) == 0) push_char(CH_BSLASH);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (byte_q.size() != 0 || tx_busy || pending_tokens.size() != 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_byte(cur_item);
        tx_busy = 1'b0;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (tx_gap > 0) begin
          tx_gap   <= tx_gap - 1;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          tx_gap   <= $urandom_range(0, 9);
          s_tvalid <= 1'b0;
        end else if (byte_q.size() != 0) begin
          cur_item = byte_q.pop_front();
          tx_busy  = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata  <= cur_item.ch;
          s_tuser  <= cur_item.first;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else if (rx_gap > 0) begin
      rx_gap   <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_gap   <= $urandom_range(0, 9);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst && m_tvalid && m_tready) begin
      n_tokens++;
      if (m_tuser == TK_ERROR) n_err_tokens++;
      if (pending_tokens.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= SHOW_FAILS)
          $display("unexpected token: kind %0d char %02h", m_tuser, m_tdata);
      end else begin
        want = pending_tokens.pop_front();
        if (m_tuser !== want.kind || m_tdata !== want.chr) begin
          fail_cnt++;
          if (fail_cnt <= SHOW_FAILS)
            $display("token %0d mismatch: kind exp %0d got %0d, char exp %02h got %02h",
                     n_tokens, want.kind, m_tuser, want.chr, m_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d tokens outstanding",
               stall_cnt, pending_tokens.size());
      $display("regex_pattern_tokenizer test failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    bit paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_tab[k]) byte_q.insert(byte_q.size(), dir_tab[k]);
    drain();
    n_live = 0;
    while (n_live < RAND_BYTES) begin
      if (n_live >= RAND_BYTES - 100) idle_on = 1'b0;
      if (!paused && n_live >= RAND_BYTES / 2) begin
        paused = 1'b1;
        drain();
      end
      if (byte_q.size() < 16) add_pattern();
      @(posedge clk);
    end
    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d pattern bytes in %0d random patterns plus the directed table",
             n_bytes, n_patterns);
    $display("checked %0d tokens (%0d error tokens), %0d mismatches",
             n_tokens, n_err_tokens, fail_cnt);
    if (fail_cnt == 0 && pending_tokens.size() == 0) begin
      $display("regex_pattern_tokenizer test passed");
    end else begin
      $display("regex_pattern_tokenizer test failed");
    end
    $finish;
  end

endmodule
